[hdl/vif_pkg.sv]
package vif_pkg;

   // payload widths
   localparam int VALUE_W     = 63;
   localparam int WORK_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 11;
   localparam int GRP_W       = 7;
   localparam int BYTE_W      = 8;

   // record length counter
   localparam int            REC_W      = 4;
   localparam logic [REC_W-1:0] MAX_RECORD = 4'd10;

   // default ring size
   localparam int RING_BYTES_DEF = 1024;

   // byte codes
   localparam logic [GRP_W-1:0]  GROUP_MASK    = 7'h7f;
   localparam logic [BYTE_W-1:0] BYTE_MORE     = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_ONES_END = 8'h7f;

   // commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // what the group unit reports about one 7-bit group
   typedef struct packed {
      logic [GRP_W-1:0] grp;
      logic             ends_zero;
      logic             ends_ones;
   } vif_group_type;

endpackage

[hdl/varint_packed_integer_fifo.sv]
// FIFO of signed 63-bit integers kept as varint records (1 to 10 bytes) in a byte ring of
// RING_BYTES entries. Issue a transaction by raising start while busy is low; req_command 0
// pushes req_value, 1 pops the head integer. Every transaction gives exactly one response,
// shown for a single cycle with rsp_valid high; the receiver cannot stall it, so sample it
// on that cycle. All byte traffic goes through one single-port byte memory, one byte per
// cycle; a pop first spends the S_POP_PRIME state on the first memory read. A push that
// does not fit stops at the first byte that would not fit, and a pop from an empty FIFO
// answers on the next cycle without raising busy. The response is shown in the first
// cycle with busy low, and a new transaction may be issued in that same cycle. The ring
// contents need no clearing after reset; only the head pointer, the counts, the state
// and the response strobe are reset.
module varint_packed_integer_fifo #(
   parameter int RING_BYTES = vif_pkg::RING_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic signed [vif_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   output logic signed [vif_pkg::VALUE_W-1:0]   rsp_popped_value,
   output logic [vif_pkg::STATUS_W-1:0]         rsp_status,
   output logic [vif_pkg::COUNT_OUT_W-1:0]      rsp_items_held,
   output logic [vif_pkg::COUNT_OUT_W-1:0]      rsp_bytes_used
);
   import vif_pkg::*;

   localparam int ADDR_W = $clog2(RING_BYTES);
   localparam int CNT_W  = $clog2(RING_BYTES + 1);
   localparam logic [ADDR_W-1:0] RING_LAST = ADDR_W'(RING_BYTES - 1);
   localparam logic [CNT_W-1:0]  RING_SIZE = CNT_W'(RING_BYTES);
   localparam logic [CNT_W:0]    RING_WIDE = (CNT_W + 1)'(RING_BYTES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PUSH,
      S_POP_PRIME,
      S_POP_BYTE
   } state_type;

   // sequencer state
   state_type          state_ff, state_in;
   logic [WORK_W-1:0]  v_ff, v_in;           // value still to encode
   logic               pend_ff, pend_in;     // all-ones trailer byte still owed
   logic [REC_W-1:0]   k_ff, k_in;           // byte index within the record
   logic [CNT_W-1:0]   free_ff, free_in;     // free bytes at push start
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;       // pop accumulator

   // fifo bookkeeping
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   items_ff, items_in;

   // response registers
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0]   rsp_items_ff, rsp_items_in;
   logic [COUNT_OUT_W-1:0]   rsp_bytes_ff, rsp_bytes_in;

   // memory port
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [BYTE_W-1:0]  ram_wdata;
   logic [BYTE_W-1:0]  ram_rdata;

   // group / shift unit
   logic [WORK_W-1:0]  v_shifted;
   vif_group_type      grp_info;

   // helpers
   logic [CNT_W:0]     tail_sum;
   logic [CNT_W:0]     tail_wrap;
   logic [ADDR_W-1:0]  tail_ptr;
   logic [REC_W-1:0]   k_inc;
   logic               rec_full;
   logic               push_last;
   logic               set_pend;
   logic               room_ok;
   logic [CNT_W-1:0]   fill_left;
   logic               byte_ends;
   logic [VALUE_W-1:0] acc_next;

   function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
      return (p == RING_LAST) ? '0 : p + 1'b1;
   endfunction

   vif_ram #(
      .DEPTH  (RING_BYTES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   vif_group_unit u_group (
      .work_value    (v_ff),
      .shifted_value (v_shifted),
      .info          (grp_info)
   );

   // tail = head + fill, wrapped once
   assign tail_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(fill_ff);
   assign tail_wrap = tail_sum - RING_WIDE;
   assign tail_ptr  = (tail_sum >= RING_WIDE) ? tail_wrap[ADDR_W-1:0] : tail_sum[ADDR_W-1:0];

   assign k_inc    = k_ff + 1'b1;
   assign rec_full = (k_inc == MAX_RECORD);

   // push: byte to emit this cycle and whether it closes the record
   always_comb begin
      if (pend_ff) begin
         ram_wdata = BYTE_ONES_END;
      end else if (grp_info.ends_zero) begin
         ram_wdata = {1'b0, grp_info.grp};
      end else begin
         ram_wdata = BYTE_MORE | {1'b0, grp_info.grp};
      end
   end

   assign push_last = pend_ff || grp_info.ends_zero || rec_full;
   assign set_pend  = !pend_ff && grp_info.ends_ones && !rec_full;
   assign room_ok   = CNT_W'(k_ff) < free_ff;

   // pop: merge the incoming byte into its 7-bit slot; an all-ones end byte fills upward
   assign fill_left = fill_ff - CNT_W'(k_inc);
   assign byte_ends = !ram_rdata[BYTE_W-1] || (fill_left == '0);

   always_comb begin
      acc_next = acc_ff;
      for (int j = 0; j < VALUE_W / GRP_W; j++) begin
         if (k_ff == REC_W'(j)) begin
            acc_next[GRP_W*j +: GRP_W] = ram_rdata[GRP_W-1:0];
         end
         if ((ram_rdata == BYTE_ONES_END) && (k_ff < REC_W'(j))) begin
            acc_next[GRP_W*j +: GRP_W] = '1;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      pend_in       = pend_ff;
      k_in          = k_ff;
      free_in       = free_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      acc_in        = acc_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      items_in      = items_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_items_in  = rsp_items_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      ram_we        = 1'b0;
      ram_addr      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_command == CMD_POP) begin
                  if (fill_ff == '0) begin
                     // empty pop answers right away
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = ST_EMPTY;
                     rsp_items_in  = COUNT_OUT_W'(items_ff);
                     rsp_bytes_in  = COUNT_OUT_W'(fill_ff);
                  end else begin
                     state_in = S_POP_PRIME;
                  end
               end else begin
                  v_in      = {req_value[VALUE_W-1], req_value};
                  pend_in   = 1'b0;
                  k_in      = '0;
                  free_in   = RING_SIZE - fill_ff;
                  wr_ptr_in = tail_ptr;
                  state_in  = S_PUSH;
               end
            end
         end

         S_PUSH: begin
            if (!room_ok) begin
               // record does not fit: bytes already written sit in free space, drop them
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = ST_FULL;
               rsp_items_in  = COUNT_OUT_W'(items_ff);
               rsp_bytes_in  = COUNT_OUT_W'(fill_ff);
            end else begin
               ram_we    = 1'b1;
               ram_addr  = wr_ptr_ff;
               wr_ptr_in = ptr_inc(wr_ptr_ff);
               k_in      = k_inc;
               pend_in   = set_pend;
               v_in      = v_shifted;
               if (push_last) begin
                  fill_in       = fill_ff + CNT_W'(k_inc);
                  items_in      = items_ff + 1'b1;
                  state_in      = S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = ST_OK;
                  rsp_items_in  = COUNT_OUT_W'(items_ff + 1'b1);
                  rsp_bytes_in  = COUNT_OUT_W'(fill_ff + CNT_W'(k_inc));
               end
            end
         end

         S_POP_PRIME: begin
            ram_addr  = head_ff;
            rd_ptr_in = ptr_inc(head_ff);
            k_in      = '0;
            acc_in    = '0;
            state_in  = S_POP_BYTE;
         end

         S_POP_BYTE: begin
            // read of the following byte goes out while this one is decoded
            ram_addr  = rd_ptr_ff;
            rd_ptr_in = ptr_inc(rd_ptr_ff);
            k_in      = k_inc;
            acc_in    = acc_next;
            if (byte_ends) begin
               head_in       = rd_ptr_ff;
               fill_in       = fill_left;
               items_in      = (items_ff != '0) ? items_ff - 1'b1 : items_ff;
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = acc_next;
               rsp_status_in = ST_OK;
               rsp_items_in  = COUNT_OUT_W'((items_ff != '0) ? items_ff - 1'b1 : items_ff);
               rsp_bytes_in  = COUNT_OUT_W'(fill_left);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         items_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         items_ff     <= items_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff          <= v_in;
      pend_ff       <= pend_in;
      k_ff          <= k_in;
      free_ff       <= free_in;
      wr_ptr_ff     <= wr_ptr_in;
      rd_ptr_ff     <= rd_ptr_in;
      acc_ff        <= acc_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_items_ff  <= rsp_items_in;
      rsp_bytes_ff  <= rsp_bytes_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_items_held   = rsp_items_ff;
   assign rsp_bytes_used   = rsp_bytes_ff;

   // bytes and integers are held together or not at all
   a_counts_agree: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) == (items_ff == '0))
      else $error("byte count and integer count disagree");

   // ring never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= RING_SIZE)
      else $error("ring holds more bytes than its size");

   // a push transaction always occupies the sequencer
   a_push_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_PUSH)) |=> busy)
      else $error("push accepted without going busy");

   // a response only leaves once the sequencer is done
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("response strobe while busy");

endmodule

[hdl/vif_ram.sv]
module vif_ram #(
   parameter int DEPTH  = vif_pkg::RING_BYTES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [vif_pkg::BYTE_W-1:0] wr_data,
   output logic [vif_pkg::BYTE_W-1:0] rd_data
);
   import vif_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rdata_ff <= mem[addr];
   end

   assign rd_data = rdata_ff;

endmodule

[hdl/vif_group_unit.sv]
module vif_group_unit (
   input  logic [vif_pkg::WORK_W-1:0] work_value,
   output logic [vif_pkg::WORK_W-1:0] shifted_value,
   output vif_pkg::vif_group_type     info
);
   import vif_pkg::*;

   // arithmetic shift right by one group
   assign shifted_value = {{GRP_W{work_value[WORK_W-1]}}, work_value[WORK_W-1:GRP_W]};

   always_comb begin
      info.grp       = work_value[GRP_W-1:0];
      info.ends_zero = (shifted_value == '0) && (work_value[GRP_W-1:0] != GROUP_MASK);
      info.ends_ones = (shifted_value == '1);
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import vif_pkg::*;

   localparam int RING_DEPTH   = RING_BYTES_DEF;
   localparam int RANDOM_ITEMS = 1300;
   // the last stretch of items goes without sender gaps
   localparam int CALM_TAIL    = 150;
   // cycles with no accepted transaction and no response before the run is called hung
   localparam int STALL_LIMIT  = 2000;
   // settle time after the last response
   localparam int SETTLE_CYCLES = 30;

   // one response transaction, field by field
   typedef struct packed {
      logic signed [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0]        status;
      logic [COUNT_OUT_W-1:0]     items;
      logic [COUNT_OUT_W-1:0]     bytes;
   } fifo_rsp_t;

   // one row of the directed table; typed rows carry their own answer
   typedef struct packed {
      logic                       cmd;
      logic signed [VALUE_W-1:0]  val;
      logic                       typed;
      fifo_rsp_t                  rsp;
   } step_row_t;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_command;
   logic signed [VALUE_W-1:0]  req_value;
   logic                       rsp_valid;
   logic signed [VALUE_W-1:0]  rsp_popped_value;
   logic [STATUS_W-1:0]        rsp_status;
   logic [COUNT_OUT_W-1:0]     rsp_items_held;
   logic [COUNT_OUT_W-1:0]     rsp_bytes_used;

   // typed answer that travels with the transaction on the request ports
   logic                       typed_valid;
   fifo_rsp_t                  typed_rsp;

   fifo_rsp_t                  pending_rsp_q[$];
   step_row_t                  directed_rows[$];
   int                         fail_count = 0;
   int                         stall_cycles = 0;

   // shadow copy of the ring and its counters
   logic [BYTE_W-1:0]          ring_mem [0:RING_DEPTH-1];
   int unsigned                head_idx;
   int unsigned                fill_cnt;
   int unsigned                item_cnt;

   varint_packed_integer_fifo #(
      .RING_BYTES(RING_DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_items_held   (rsp_items_held),
      .rsp_bytes_used   (rsp_bytes_used)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the shadow fifo by one transaction and return its response
   function automatic fifo_rsp_t predict_transaction(input logic cmd,
                                                     input logic signed [VALUE_W-1:0] val);
      fifo_rsp_t               r;
      logic signed [WORK_W-1:0] work;
      logic [79:0]             rec;
      logic [GRP_W-1:0]        grp;
      logic [BYTE_W-1:0]       b;
      logic [WORK_W-1:0]       acc;
      int                      n;
      int                      sh;
      bit                      done;
      r.value  = '0;
      r.status = ST_OK;
      if (cmd == CMD_PUSH) begin
         // sign extend to 64 bits, then peel 7-bit groups, lsb group first
         work = val;
         rec  = '0;
         n    = 0;
         done = 1'b0;
         while (!done && n < int'(MAX_RECORD)) begin
            grp  = work[GRP_W-1:0];
            work = work >>> GRP_W;
            if (work == 0 && grp != GROUP_MASK) begin
               // plain last byte
               rec[n*8 +: 8] = {1'b0, grp};
               n++;
               done = 1'b1;
            end else if (&work) begin
               // rest is all ones: continuation byte, then the ones marker
               rec[n*8 +: 8] = BYTE_MORE | {1'b0, grp};
               n++;
               if (n < int'(MAX_RECORD)) begin
                  rec[n*8 +: 8] = BYTE_ONES_END;
                  n++;
               end
               done = 1'b1;
            end else begin
               rec[n*8 +: 8] = BYTE_MORE | {1'b0, grp};
               n++;
            end
         end
         if (fill_cnt + n > RING_DEPTH) begin
            // whole record must fit or nothing is written
            r.status = ST_FULL;
         end else begin
            for (int k = 0; k < n; k++) begin
               ring_mem[(head_idx + fill_cnt) % RING_DEPTH] = rec[k*8 +: 8];
               fill_cnt++;
            end
            item_cnt++;
         end
      end else if (fill_cnt == 0) begin
         r.status = ST_EMPTY;
      end else begin
         acc  = '0;
         sh   = 0;
         done = 1'b0;
         while (!done && fill_cnt > 0) begin
            b        = ring_mem[head_idx];
            head_idx = (head_idx + 1) % RING_DEPTH;
            fill_cnt--;
            if (b[BYTE_W-1]) begin
               if (sh < WORK_W) acc |= WORK_W'(b[GRP_W-1:0]) << sh;
            end else if (b == BYTE_ONES_END) begin
               // ones marker: every bit from here up is set
               if (sh < WORK_W) acc |= ~WORK_W'(0) << sh;
               done = 1'b1;
            end else begin
               if (sh < WORK_W) acc |= WORK_W'(b) << sh;
               done = 1'b1;
            end
            sh += GRP_W;
         end
         if (item_cnt > 0) item_cnt--;
         r.value = acc[VALUE_W-1:0];
      end
      r.items = COUNT_OUT_W'(item_cnt);
      r.bytes = COUNT_OUT_W'(fill_cnt);
      return r;
   endfunction

   // random push operand: mostly short records, with some full-width values
   function automatic logic signed [VALUE_W-1:0] random_operand();
      logic [WORK_W-1:0] raw;
      int                width;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: begin
            return raw[VALUE_W-1:0];
         end
         1: begin
            case ($urandom_range(0, 5))
               0: return 63'sh3fff_ffff_ffff_ffff;
               1: return 63'sh4000_0000_0000_0000;
               2: return -63'sd1;
               3: return 63'sd127;
               4: return -63'sd128;
               default: return 63'sd0;
            endcase
         end
         default: begin
            width = $urandom_range(0, VALUE_W - 1);
            raw   = raw & ((WORK_W'(1) << width) - 1);
            // inverting gives the matching negative range
            if ($urandom_range(0, 1) == 1) raw = ~raw;
            return raw[VALUE_W-1:0];
         end
      endcase
   endfunction

   task automatic compare_field(input string name, input logic [WORK_W-1:0] want,
                                input logic [WORK_W-1:0] got);
      if (got !== want) begin
         $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // present one transaction and hold it until the block takes it
   task automatic issue(input logic cmd, input logic signed [VALUE_W-1:0] val,
                        input logic typed, input fifo_rsp_t rsp);
      @(negedge clock);
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      typed_valid <= typed;
      typed_rsp   <= rsp;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // sender holds off until every issued transaction has answered
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic cmd, input logic signed [VALUE_W-1:0] val,
                          input logic typed, input logic [STATUS_W-1:0] status,
                          input int items, input int bytes);
      step_row_t row;
      row.cmd        = cmd;
      row.val        = val;
      row.typed      = typed;
      row.rsp.value  = '0;
      row.rsp.status = status;
      row.rsp.items  = COUNT_OUT_W'(items);
      row.rsp.bytes  = COUNT_OUT_W'(bytes);
      directed_rows.push_back(row);
   endtask

   // response checker, predictor hookup and hang watchdog, all sampled at the rising edge
   always @(posedge clock) begin : rsp_monitor
      fifo_rsp_t want;
      logic      accepted;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         accepted = start && !busy;
         if (rsp_valid) begin
            if (pending_rsp_q.size() == 0) begin
               $display("%0t response with no transaction pending: value %h status %h",
                        $time, rsp_popped_value, rsp_status);
               fail_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               compare_field("popped_value", WORK_W'(want.value), WORK_W'(rsp_popped_value));
               compare_field("status", WORK_W'(want.status), WORK_W'(rsp_status));
               compare_field("items_held", WORK_W'(want.items), WORK_W'(rsp_items_held));
               compare_field("bytes_used", WORK_W'(want.bytes), WORK_W'(rsp_bytes_used));
            end
         end
         if (accepted) begin
            // shadow state always advances; typed rows override the answer
            want = predict_transaction(req_command, req_value);
            if (typed_valid) want = typed_rsp;
            pending_rsp_q.push_back(want);
         end
         if (rsp_valid || accepted) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles, %0d responses pending",
                     $time, stall_cycles, pending_rsp_q.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int        item_idx;
      int        phase_len;
      int        push_pct;
      bit        idle_on;
      logic      cmd;
      fifo_rsp_t no_rsp;

      no_rsp      = '0;
      reset       = 1'b1;
      start       = 1'b0;
      req_command = CMD_PUSH;
      req_value   = '0;
      typed_valid = 1'b0;
      typed_rsp   = '0;
      head_idx    = 0;
      fill_cnt    = 0;
      item_cnt    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: empty pop after reset, then the encoding corner values
      add_row(CMD_POP,  63'sd0, 1'b1, ST_EMPTY, 0, 0);
      add_row(CMD_PUSH, 63'sd0, 1'b1, ST_OK, 1, 1);
      add_row(CMD_POP,  63'sd0, 1'b1, ST_OK, 0, 0);
      add_row(CMD_PUSH, 63'sh3fff_ffff_ffff_ffff, 1'b0, ST_OK, 0, 0);   // most positive
      add_row(CMD_PUSH, 63'sh4000_0000_0000_0000, 1'b0, ST_OK, 0, 0);   // most negative
      add_row(CMD_PUSH, -63'sd1, 1'b0, ST_OK, 0, 0);                    // all ones
      add_row(CMD_PUSH, 63'sd63, 1'b0, ST_OK, 0, 0);
      add_row(CMD_PUSH, 63'sd64, 1'b0, ST_OK, 0, 0);
      add_row(CMD_PUSH, 63'sd127, 1'b0, ST_OK, 0, 0);                   // group equal to marker
      add_row(CMD_PUSH, 63'sd128, 1'b0, ST_OK, 0, 0);
      add_row(CMD_PUSH, -63'sd64, 1'b0, ST_OK, 0, 0);
      add_row(CMD_PUSH, -63'sd65, 1'b0, ST_OK, 0, 0);
      add_row(CMD_PUSH, -63'sd128, 1'b0, ST_OK, 0, 0);
      add_row(CMD_PUSH, 63'sh2aaa_aaaa_aaaa_aaaa, 1'b0, ST_OK, 0, 0);
      add_row(CMD_PUSH, 63'sh5555_5555_5555_5555, 1'b0, ST_OK, 0, 0);
      repeat (12) add_row(CMD_POP, 63'sh7fff_ffff_ffff_ffff, 1'b0, ST_OK, 0, 0);
      add_row(CMD_POP,  63'sd0, 1'b1, ST_EMPTY, 0, 0);

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].typed,
               directed_rows[i].rsp);
      end
      wait_for_drain();

      // random phases: fill-heavy, drain-heavy and balanced, so the ring wraps,
      // fills up and empties many times
      item_idx = 0;
      while (item_idx < RANDOM_ITEMS) begin
         phase_len = $urandom_range(80, 250);
         case ($urandom_range(0, 2))
            0: push_pct = 90;
            1: push_pct = 15;
            default: push_pct = 55;
         endcase
         idle_on = ($urandom_range(0, 2) != 0);
         for (int j = 0; j < phase_len && item_idx < RANDOM_ITEMS; j++) begin
            if (idle_on && item_idx < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0)
               idle_gap($urandom_range(1, 19));
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            // pops get a random operand too, the block must ignore it
            if (cmd == CMD_PUSH) issue(cmd, random_operand(), 1'b0, no_rsp);
            else issue(cmd, VALUE_W'({$urandom, $urandom}), 1'b0, no_rsp);
            item_idx++;
         end
         if ($urandom_range(0, 1) == 1) wait_for_drain();
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
